@@ hw/rtl/icid_pkg.sv @@
// ----------------------------------------------------------------------------
// icid_pkg: shared types, constants and saturation helpers
// Holds the sequencer state type, fixed datapath widths, configuration
// register indexes and the saturating arithmetic used by the integrator.
// ----------------------------------------------------------------------------
package icid_pkg;

    // Fixed datapath widths: Q16.16 samples, Q16.48 accumulators.
    localparam int SAMPLE_W   = 32;
    localparam int ACC_W      = 64;
    localparam int PROD_W     = 2 * ACC_W;
    localparam int FRAC_W     = ACC_W - 16;
    localparam int CONE_SHIFT = FRAC_W + 1;
    localparam int OUT_SHIFT_PASS = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNITS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORATE  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [15:0] RATIO_RST = 16'd1;
    localparam logic [31:0] SPER_RST  = 32'd4294967;
    localparam logic [31:0] OPER_RST  = 32'd4294967;
    localparam logic [31:0] ORATE_RST = 32'd65536000;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DLT_GO,
        ST_DLT_WAIT,
        ST_CRS_GO,
        ST_CRS_WAIT,
        ST_OUT_GO,
        ST_OUT_WAIT,
        ST_DONE
    } state_t;

    // Saturating add of two accumulator words.
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

    // Saturate a full product word to the accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_to_acc(input logic signed [PROD_W-1:0] x);
        if (x[PROD_W-1:ACC_W-1] != {(PROD_W-ACC_W+1){x[PROD_W-1]}})
            return x[PROD_W-1] ? ACC_MIN : ACC_MAX;
        return x[ACC_W-1:0];
    endfunction

    // Saturate a full product word to the sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat_to_smp(input logic signed [PROD_W-1:0] x);
        if (x[PROD_W-1:SAMPLE_W-1] != {(PROD_W-SAMPLE_W+1){x[PROD_W-1]}})
            return x[PROD_W-1] ? SMP_MIN : SMP_MAX;
        return x[SAMPLE_W-1:0];
    endfunction

    // Sign-extend a sample to accumulator width.
    function automatic logic signed [ACC_W-1:0] sext(input logic signed [SAMPLE_W-1:0] v);
        return {{(ACC_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

endpackage

@@ hw/rtl/icid_mul.sv @@
// ----------------------------------------------------------------------------
// icid_mul: shared signed 64x64 multiplier
// Forms the exact 128-bit product from four 32x32 partial products over
// successive cycles, then restores the sign.
// ----------------------------------------------------------------------------
module icid_mul (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [icid_pkg::ACC_W-1:0]     op_a,
    input  logic signed [icid_pkg::ACC_W-1:0]     op_b,
    output logic                                  busy,
    output logic                                  done,
    output logic signed [icid_pkg::PROD_W-1:0]    product
);

    localparam int HW = icid_pkg::ACC_W / 2;

    logic                              busy_reg, busy_next;
    logic [2:0]                        step_reg, step_next;
    logic                              done_reg, done_next;
    logic                              neg_reg, neg_next;
    logic [icid_pkg::ACC_W-1:0]        ua_reg, ua_next;
    logic [icid_pkg::ACC_W-1:0]        ub_reg, ub_next;
    logic [icid_pkg::ACC_W-1:0]        pp_reg, pp_next;
    logic [1:0]                        pp_sh_reg, pp_sh_next;
    logic [icid_pkg::PROD_W-1:0]       acc_reg, acc_next;
    logic signed [icid_pkg::PROD_W-1:0] prod_reg, prod_next;

    logic [HW-1:0]                     a_half;
    logic [HW-1:0]                     b_half;
    logic [icid_pkg::PROD_W-1:0]       pp_word;

    always_comb
    begin
        a_half = step_reg[1] ? ua_reg[icid_pkg::ACC_W-1:HW] : ua_reg[HW-1:0];
        b_half = step_reg[0] ? ub_reg[icid_pkg::ACC_W-1:HW] : ub_reg[HW-1:0];
        case (pp_sh_reg)
            2'd0:    pp_word = {{icid_pkg::ACC_W{1'b0}}, pp_reg};
            2'd1:    pp_word = {{HW{1'b0}}, pp_reg, {HW{1'b0}}};
            default: pp_word = {pp_reg, {icid_pkg::ACC_W{1'b0}}};
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        ua_next    = ua_reg;
        ub_next    = ub_reg;
        pp_next    = pp_reg;
        pp_sh_next = pp_sh_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = 3'd0;
                neg_next  = op_a[icid_pkg::ACC_W-1] ^ op_b[icid_pkg::ACC_W-1];
                ua_next   = op_a[icid_pkg::ACC_W-1] ? (~op_a + 1'b1) : op_a;
                ub_next   = op_b[icid_pkg::ACC_W-1] ? (~op_b + 1'b1) : op_b;
                acc_next  = '0;
            end
        end
        else
        begin
            step_next = step_reg + 3'd1;
            if (step_reg < 3'd4)
            begin
                pp_next    = a_half * b_half;
                pp_sh_next = {1'b0, step_reg[1]} + {1'b0, step_reg[0]};
            end
            if (step_reg >= 3'd1 && step_reg <= 3'd4)
                acc_next = acc_reg + pp_word;
            if (step_reg == 3'd5)
            begin
                prod_next = neg_reg ? (~acc_reg + 1'b1) : acc_reg;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        ua_reg    <= ua_next;
        ub_reg    <= ub_next;
        pp_reg    <= pp_next;
        pp_sh_reg <= pp_sh_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = prod_reg;

endmodule

@@ hw/rtl/icid_div6.sv @@
// ----------------------------------------------------------------------------
// icid_div6: serial divide by six
// Divides a signed 64-bit word by six, truncating toward zero, one byte of
// quotient per cycle using a reciprocal multiply on the partial remainder.
// ----------------------------------------------------------------------------
module icid_div6 (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [icid_pkg::ACC_W-1:0]  dividend,
    output logic                               done,
    output logic signed [icid_pkg::ACC_W-1:0]  quotient
);

    localparam int W       = icid_pkg::ACC_W;
    localparam int DIGIT_W = 8;
    localparam int STEPS   = W / DIGIT_W;
    localparam int T_W     = DIGIT_W + 3;
    localparam int RCP_W   = 14;
    localparam int RCP_SH  = 16;
    localparam logic [RCP_W-1:0] RECIP6 = 14'd10923;
    localparam int CNT_W   = $clog2(STEPS + 1);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      step_reg, step_next;
    logic                  done_reg, done_next;
    logic                  neg_reg, neg_next;
    logic [W-1:0]          mag_reg, mag_next;
    logic [2:0]            rem_reg, rem_next;
    logic [W-1:0]          q_reg, q_next;
    logic signed [W-1:0]   quot_reg, quot_next;

    logic [T_W-1:0]          t_val;
    logic [T_W+RCP_W-1:0]    t_scaled;
    logic [DIGIT_W-1:0]      q_digit;
    logic [T_W-1:0]          r_val;

    always_comb
    begin
        t_val    = {rem_reg, mag_reg[W-1:W-DIGIT_W]};
        t_scaled = t_val * RECIP6;
        q_digit  = t_scaled[RCP_SH+DIGIT_W-1:RCP_SH];
        r_val    = t_val - (({3'b0, q_digit} << 2) + ({3'b0, q_digit} << 1));
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        quot_next = quot_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = '0;
                neg_next  = dividend[W-1];
                mag_next  = dividend[W-1] ? (~dividend + 1'b1) : dividend;
                rem_next  = 3'd0;
                q_next    = '0;
            end
        end
        else if (step_reg == CNT_W'(STEPS))
        begin
            quot_next = neg_reg ? (~q_reg + 1'b1) : q_reg;
            done_next = 1'b1;
            busy_next = 1'b0;
        end
        else
        begin
            step_next = step_reg + 1'b1;
            mag_next  = mag_reg << DIGIT_W;
            rem_next  = r_val[2:0];
            q_next    = {q_reg[W-DIGIT_W-1:0], q_digit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

@@ hw/rtl/imu_coning_integrator_downsampler.sv @@
// ----------------------------------------------------------------------------
// imu_coning_integrator_downsampler: coning-compensated IMU integrator
// Integrates gyro and accel ticks with coning correction, or holds raw
// samples, and emits one downsampled, saturated Q16.16 result per interval.
// ----------------------------------------------------------------------------
// Usage. Sensor ticks enter on the in_valid/in_ready request channel, one
// request per tick. Results leave on the out_valid/out_ready channel. The
// configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; it must only be written while the block is idle.
// Sequencing. A killed tick, or one that neither starts integration nor
// finishes an interval, leaves the block idle. In integrate mode, a tick
// with fresh gyro and accel runs three serial divides by six and twelve
// products on the one shared 64x64 multiplier. An emitted result adds six
// more products and a final commit state in either mode.
// The block is not ready while a tick is in work.
// Reset clears all integration and held state, the kill flag and the
// sequence number, loads the countdown with one and the registers with their
// defaults. A finished result sits in the output register; if the receiver
// stalls, the next tick is still taken, and the block waits only when a
// further result is ready and the output register is still occupied.
// ----------------------------------------------------------------------------
module imu_coning_integrator_downsampler (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [icid_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [31:0]                              cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic signed [icid_pkg::SAMPLE_W-1:0]     gyro_x,
    input  logic signed [icid_pkg::SAMPLE_W-1:0]     gyro_y,
    input  logic signed [icid_pkg::SAMPLE_W-1:0]     gyro_z,
    input  logic signed [icid_pkg::SAMPLE_W-1:0]     accel_x,
    input  logic signed [icid_pkg::SAMPLE_W-1:0]     accel_y,
    input  logic signed [icid_pkg::SAMPLE_W-1:0]     accel_z,
    input  logic                                     gyro_fresh,
    input  logic                                     accel_fresh,
    input  logic                                     kill_valid,
    input  logic                                     kill_level,
    input  logic                                     bump_sequence,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [icid_pkg::SAMPLE_W-1:0]     out_gyro_x,
    output logic signed [icid_pkg::SAMPLE_W-1:0]     out_gyro_y,
    output logic signed [icid_pkg::SAMPLE_W-1:0]     out_gyro_z,
    output logic signed [icid_pkg::SAMPLE_W-1:0]     out_accel_x,
    output logic signed [icid_pkg::SAMPLE_W-1:0]     out_accel_y,
    output logic signed [icid_pkg::SAMPLE_W-1:0]     out_accel_z,
    output logic [31:0]                              out_sequence
);

    localparam int SW = icid_pkg::SAMPLE_W;
    localparam int AW = icid_pkg::ACC_W;
    localparam int PW = icid_pkg::PROD_W;

    // Configuration registers.
    logic [15:0] ratio_reg;
    logic        mode_reg;
    logic        units_reg;
    logic [31:0] sper_reg;
    logic [31:0] oper_reg;
    logic [31:0] orate_reg;

    icid_pkg::state_t state_reg, state_next;
    logic [icid_pkg::STEP_W-1:0] step_reg, step_next;

    // Architectural state. All vectors rotate through position zero so the
    // datapath reads fixed places only.
    logic signed [AW-1:0] angle_reg [3];
    logic signed [AW-1:0] angle_next [3];
    logic signed [AW-1:0] prior_reg [3];
    logic signed [AW-1:0] prior_next [3];
    logic signed [AW-1:0] coning_reg [3];
    logic signed [AW-1:0] coning_next [3];
    logic signed [AW-1:0] vel_reg [3];
    logic signed [AW-1:0] vel_next [3];
    logic signed [SW-1:0] hrate_reg [3];
    logic signed [SW-1:0] hrate_next [3];
    logic signed [SW-1:0] haccel_reg [3];
    logic signed [SW-1:0] haccel_next [3];
    logic [15:0]          cd_reg, cd_next;
    logic                 halted_reg, halted_next;
    logic [31:0]          seq_reg, seq_next;
    logic                 emit_reg, emit_next;
    logic                 bump_reg, bump_next;
    logic                 out_valid_reg, out_valid_next;

    // Working registers for the tick in progress.
    logic signed [SW-1:0] gin_reg [3];
    logic signed [SW-1:0] gin_next [3];
    logic signed [SW-1:0] ain_reg [3];
    logic signed [SW-1:0] ain_next [3];
    logic signed [AW-1:0] c_reg [3];
    logic signed [AW-1:0] c_next [3];
    logic signed [AW-1:0] d_reg [3];
    logic signed [AW-1:0] d_next [3];
    logic signed [PW-1:0] p_reg, p_next;
    logic signed [SW-1:0] res_reg [6];
    logic signed [SW-1:0] res_next [6];
    logic signed [SW-1:0] ores_reg [6];
    logic signed [SW-1:0] ores_next [6];
    logic [31:0]          oseq_reg, oseq_next;

    // Shared units.
    logic                 mul_start;
    logic                 mul_busy;
    logic                 mul_done;
    logic signed [AW-1:0] mul_a;
    logic signed [AW-1:0] mul_b;
    logic signed [PW-1:0] mul_prod;
    logic                 div_start;
    logic                 div_done;
    logic signed [AW-1:0] div_q;

    logic                 accept;
    logic                 halt_now;
    logic                 pair_fresh;
    logic [15:0]          cd_dec;
    logic                 emit_now;
    logic                 slot_free;
    logic                 last3;
    logic                 last6;
    logic signed [AW-1:0] out_src;
    logic signed [AW-1:0] out_factor;
    logic signed [PW-1:0] cross_diff;
    logic signed [PW-1:0] out_shifted;

    icid_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_prod)
    );

    icid_div6 u_div6 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prior_reg[0]),
        .done     (div_done),
        .quotient (div_q)
    );

    // Configuration writes; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= icid_pkg::RATIO_RST;
            mode_reg  <= 1'b0;
            units_reg <= 1'b0;
            sper_reg  <= icid_pkg::SPER_RST;
            oper_reg  <= icid_pkg::OPER_RST;
            orate_reg <= icid_pkg::ORATE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                icid_pkg::CFG_RATIO: ratio_reg <= cfg_data[15:0];
                icid_pkg::CFG_MODE:  mode_reg  <= cfg_data[0];
                icid_pkg::CFG_UNITS: units_reg <= cfg_data[0];
                icid_pkg::CFG_SPER:  sper_reg  <= cfg_data;
                icid_pkg::CFG_OPER:  oper_reg  <= cfg_data;
                icid_pkg::CFG_ORATE: orate_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Tick decode at the input.
    assign accept     = in_valid && in_ready;
    assign halt_now   = kill_valid ? kill_level : halted_reg;
    assign pair_fresh = gyro_fresh && accel_fresh;
    assign cd_dec     = (gyro_fresh && cd_reg != 16'd0) ? cd_reg - 16'd1 : cd_reg;
    assign emit_now   = (cd_dec == 16'd0);
    assign slot_free  = !out_valid_reg || out_ready;
    assign last3      = (step_reg == 3'd2);
    assign last6      = (step_reg == 3'd5);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            icid_pkg::ST_IDLE:
            begin
                if (accept && !halt_now)
                begin
                    if (pair_fresh && mode_reg)
                        state_next = icid_pkg::ST_DIV_GO;
                    else if (emit_now)
                        state_next = icid_pkg::ST_OUT_GO;
                end
            end
            icid_pkg::ST_DIV_GO:   state_next = icid_pkg::ST_DIV_WAIT;
            icid_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = last3 ? icid_pkg::ST_DLT_GO : icid_pkg::ST_DIV_GO;
            end
            icid_pkg::ST_DLT_GO:   state_next = icid_pkg::ST_DLT_WAIT;
            icid_pkg::ST_DLT_WAIT:
            begin
                if (mul_done)
                    state_next = last6 ? icid_pkg::ST_CRS_GO : icid_pkg::ST_DLT_GO;
            end
            icid_pkg::ST_CRS_GO:   state_next = icid_pkg::ST_CRS_WAIT;
            icid_pkg::ST_CRS_WAIT:
            begin
                if (mul_done && last6)
                    state_next = emit_reg ? icid_pkg::ST_OUT_GO : icid_pkg::ST_IDLE;
                else if (mul_done)
                    state_next = icid_pkg::ST_CRS_GO;
            end
            icid_pkg::ST_OUT_GO:   state_next = icid_pkg::ST_OUT_WAIT;
            icid_pkg::ST_OUT_WAIT:
            begin
                if (mul_done)
                    state_next = last6 ? icid_pkg::ST_DONE : icid_pkg::ST_OUT_GO;
            end
            icid_pkg::ST_DONE:
            begin
                if (slot_free)
                    state_next = icid_pkg::ST_IDLE;
            end
            default:               state_next = icid_pkg::ST_IDLE;
        endcase
    end

    // Output value used by the scaling products: the angle sum plus coning,
    // the velocity sum, or a held sample, each scaled by a mode-chosen factor.
    always_comb
    begin
        if (mode_reg)
        begin
            out_src    = (step_reg < 3'd3) ? icid_pkg::sat_add(angle_reg[0], coning_reg[0])
                                           : vel_reg[0];
            out_factor = units_reg ? AW'(64'h1_0000) : {32'b0, orate_reg};
        end
        else
        begin
            out_src    = (step_reg < 3'd3) ? icid_pkg::sext(hrate_reg[0])
                                           : icid_pkg::sext(haccel_reg[0]);
            out_factor = units_reg ? {32'b0, oper_reg} : AW'(64'h1_0000_0000);
        end
        out_shifted = mode_reg ? (mul_prod >>> icid_pkg::FRAC_W)
                               : (mul_prod >>> icid_pkg::OUT_SHIFT_PASS);
        cross_diff  = p_reg - mul_prod;
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_ready  = (state_reg == icid_pkg::ST_IDLE);
        div_start = (state_reg == icid_pkg::ST_DIV_GO);
        mul_start = (state_reg == icid_pkg::ST_DLT_GO) || (state_reg == icid_pkg::ST_CRS_GO)
                 || (state_reg == icid_pkg::ST_OUT_GO);
        unique case (state_reg)
            icid_pkg::ST_DLT_GO:
            begin
                mul_a = (step_reg < 3'd3) ? icid_pkg::sext(gin_reg[0])
                                          : icid_pkg::sext(ain_reg[0]);
                mul_b = {32'b0, sper_reg};
            end
            icid_pkg::ST_CRS_GO:
            begin
                mul_a = step_reg[0] ? c_reg[2] : c_reg[1];
                mul_b = step_reg[0] ? d_reg[1] : d_reg[2];
            end
            icid_pkg::ST_OUT_GO:
            begin
                mul_a = out_src;
                mul_b = out_factor;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        step_next      = step_reg;
        cd_next        = cd_reg;
        halted_next    = halted_reg;
        seq_next       = seq_reg;
        emit_next      = emit_reg;
        bump_next      = bump_reg;
        out_valid_next = out_valid_reg;
        p_next         = p_reg;
        oseq_next      = oseq_reg;
        for (int i = 0; i < 3; i++)
        begin
            angle_next[i]  = angle_reg[i];
            prior_next[i]  = prior_reg[i];
            coning_next[i] = coning_reg[i];
            vel_next[i]    = vel_reg[i];
            hrate_next[i]  = hrate_reg[i];
            haccel_next[i] = haccel_reg[i];
            gin_next[i]    = gin_reg[i];
            ain_next[i]    = ain_reg[i];
            c_next[i]      = c_reg[i];
            d_next[i]      = d_reg[i];
        end
        for (int i = 0; i < 6; i++)
        begin
            res_next[i]  = res_reg[i];
            ores_next[i] = ores_reg[i];
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            icid_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    halted_next = halt_now;
                    if (!halt_now)
                    begin
                        gin_next[0] = gyro_x;
                        gin_next[1] = gyro_y;
                        gin_next[2] = gyro_z;
                        ain_next[0] = accel_x;
                        ain_next[1] = accel_y;
                        ain_next[2] = accel_z;
                        if (pair_fresh && !mode_reg)
                        begin
                            hrate_next[0]  = gyro_x;
                            hrate_next[1]  = gyro_y;
                            hrate_next[2]  = gyro_z;
                            haccel_next[0] = accel_x;
                            haccel_next[1] = accel_y;
                            haccel_next[2] = accel_z;
                        end
                        // The countdown reloads as soon as the interval ends.
                        cd_next   = emit_now ? ratio_reg : cd_dec;
                        emit_next = emit_now;
                        bump_next = bump_sequence;
                        step_next = '0;
                    end
                end
            end
            icid_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    // Coning lever arm: angle sum plus a sixth of the last delta.
                    c_next[0]     = c_reg[1];
                    c_next[1]     = c_reg[2];
                    c_next[2]     = icid_pkg::sat_add(angle_reg[0], div_q);
                    angle_next[0] = angle_reg[1];
                    angle_next[1] = angle_reg[2];
                    angle_next[2] = angle_reg[0];
                    prior_next[0] = prior_reg[1];
                    prior_next[1] = prior_reg[2];
                    prior_next[2] = prior_reg[0];
                    step_next     = last3 ? '0 : step_reg + 3'd1;
                end
            end
            icid_pkg::ST_DLT_WAIT:
            begin
                if (mul_done)
                begin
                    if (step_reg < 3'd3)
                    begin
                        d_next[0]   = d_reg[1];
                        d_next[1]   = d_reg[2];
                        d_next[2]   = mul_prod[AW-1:0];
                        gin_next[0] = gin_reg[1];
                        gin_next[1] = gin_reg[2];
                        gin_next[2] = gin_reg[0];
                    end
                    else
                    begin
                        vel_next[0] = vel_reg[1];
                        vel_next[1] = vel_reg[2];
                        vel_next[2] = icid_pkg::sat_add(vel_reg[0], mul_prod[AW-1:0]);
                        ain_next[0] = ain_reg[1];
                        ain_next[1] = ain_reg[2];
                        ain_next[2] = ain_reg[0];
                    end
                    step_next = last6 ? '0 : step_reg + 3'd1;
                end
            end
            icid_pkg::ST_CRS_WAIT:
            begin
                if (mul_done)
                begin
                    if (!step_reg[0])
                        p_next = mul_prod;
                    else
                    begin
                        // One cross product axis is complete: fold in the
                        // halved term, then advance the angle for this axis.
                        coning_next[0] = coning_reg[1];
                        coning_next[1] = coning_reg[2];
                        coning_next[2] = icid_pkg::sat_add(coning_reg[0],
                            icid_pkg::sat_to_acc(cross_diff >>> icid_pkg::CONE_SHIFT));
                        angle_next[0]  = angle_reg[1];
                        angle_next[1]  = angle_reg[2];
                        angle_next[2]  = icid_pkg::sat_add(angle_reg[0], d_reg[0]);
                        prior_next[0]  = prior_reg[1];
                        prior_next[1]  = prior_reg[2];
                        prior_next[2]  = d_reg[0];
                        c_next[0]      = c_reg[1];
                        c_next[1]      = c_reg[2];
                        c_next[2]      = c_reg[0];
                        d_next[0]      = d_reg[1];
                        d_next[1]      = d_reg[2];
                        d_next[2]      = d_reg[0];
                    end
                    step_next = last6 ? '0 : step_reg + 3'd1;
                end
            end
            icid_pkg::ST_OUT_WAIT:
            begin
                if (mul_done)
                begin
                    for (int i = 0; i < 5; i++)
                        res_next[i] = res_reg[i+1];
                    res_next[5] = icid_pkg::sat_to_smp(out_shifted);
                    if (mode_reg && step_reg < 3'd3)
                    begin
                        angle_next[0]  = angle_reg[1];
                        angle_next[1]  = angle_reg[2];
                        angle_next[2]  = angle_reg[0];
                        coning_next[0] = coning_reg[1];
                        coning_next[1] = coning_reg[2];
                        coning_next[2] = coning_reg[0];
                    end
                    else if (mode_reg)
                    begin
                        vel_next[0] = vel_reg[1];
                        vel_next[1] = vel_reg[2];
                        vel_next[2] = vel_reg[0];
                    end
                    else if (step_reg < 3'd3)
                    begin
                        hrate_next[0] = hrate_reg[1];
                        hrate_next[1] = hrate_reg[2];
                        hrate_next[2] = hrate_reg[0];
                    end
                    else
                    begin
                        haccel_next[0] = haccel_reg[1];
                        haccel_next[1] = haccel_reg[2];
                        haccel_next[2] = haccel_reg[0];
                    end
                    step_next = last6 ? '0 : step_reg + 3'd1;
                end
            end
            icid_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    for (int i = 0; i < 6; i++)
                        ores_next[i] = res_reg[i];
                    seq_next       = bump_reg ? seq_reg + 32'd1 : seq_reg;
                    oseq_next      = bump_reg ? seq_reg + 32'd1 : seq_reg;
                    out_valid_next = 1'b1;
                    // An integrate emission starts a fresh interval.
                    if (mode_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            angle_next[i]  = '0;
                            prior_next[i]  = '0;
                            coning_next[i] = '0;
                            vel_next[i]    = '0;
                            hrate_next[i]  = '0;
                            haccel_next[i] = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= icid_pkg::ST_IDLE;
            step_reg      <= '0;
            cd_reg        <= icid_pkg::RATIO_RST;
            halted_reg    <= 1'b0;
            seq_reg       <= 32'd0;
            emit_reg      <= 1'b0;
            bump_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                angle_reg[i]  <= '0;
                prior_reg[i]  <= '0;
                coning_reg[i] <= '0;
                vel_reg[i]    <= '0;
                hrate_reg[i]  <= '0;
                haccel_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cd_reg        <= cd_next;
            halted_reg    <= halted_next;
            seq_reg       <= seq_next;
            emit_reg      <= emit_next;
            bump_reg      <= bump_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++)
            begin
                angle_reg[i]  <= angle_next[i];
                prior_reg[i]  <= prior_next[i];
                coning_reg[i] <= coning_next[i];
                vel_reg[i]    <= vel_next[i];
                hrate_reg[i]  <= hrate_next[i];
                haccel_reg[i] <= haccel_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        oseq_reg <= oseq_next;
        for (int i = 0; i < 3; i++)
        begin
            gin_reg[i] <= gin_next[i];
            ain_reg[i] <= ain_next[i];
            c_reg[i]   <= c_next[i];
            d_reg[i]   <= d_next[i];
        end
        for (int i = 0; i < 6; i++)
        begin
            res_reg[i]  <= res_next[i];
            ores_reg[i] <= ores_next[i];
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_gyro_x   = ores_reg[0];
    assign out_gyro_y   = ores_reg[1];
    assign out_gyro_z   = ores_reg[2];
    assign out_accel_x  = ores_reg[3];
    assign out_accel_y  = ores_reg[4];
    assign out_accel_z  = ores_reg[5];
    assign out_sequence = oseq_reg;

    // The multiplier only reports a product while the sequencer waits on it.
    a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == icid_pkg::ST_DLT_WAIT || state_reg == icid_pkg::ST_CRS_WAIT
                      || state_reg == icid_pkg::ST_OUT_WAIT))
        else $error("multiplier result outside a wait state");

    // A new tick is never taken while the shared multiplier is still busy.
    a_ready_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !mul_busy)
        else $error("input ready while multiplier busy");

    // The divider only reports while the sequencer waits on it.
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == icid_pkg::ST_DIV_WAIT)
        else $error("divider result outside its wait state");

    // A killing tick leaves the block idle on the next cycle.
    a_kill_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kill_valid && kill_level) |=> state_reg == icid_pkg::ST_IDLE)
        else $error("killed tick started work");

    // Results are only committed when the output register can take them.
    a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == icid_pkg::ST_DONE && !slot_free) |=> state_reg == icid_pkg::ST_DONE)
        else $error("result committed over a pending output");

endmodule
